FILE: design/gfl_pkg.sv
// gfl_pkg: shared widths, item types, status codes and helpers for the gap filler
`timescale 1ns / 1ps

package gfl_pkg;

  localparam int MAX_GAP     = 63;
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 16;
  localparam int FILL_W      = 32;

  // pending count, and pending count plus one (interpolation distance)
  localparam int PEND_W = $clog2(MAX_GAP + 1);
  localparam int CNT_W  = PEND_W + 1;

  // dividend/quotient width and accumulator width (two guard bits)
  localparam int NUM_W     = SAMPLE_BITS + FRAC_BITS;
  localparam int ACC_W     = NUM_W + 2;
  localparam int DIV_CNT_W = $clog2(NUM_W);

  localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_BITS - 1);

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_OVF     = 2'd1;
  localparam logic [1:0] STATUS_NOVALID = 2'd2;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          sample_valid;
    logic                          record_end;
  } gfl_in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          was_filled;
    logic [1:0]                    status;
    logic                          run_last;
    logic                          record_done;
    logic [FILL_W-1:0]             filled_total;
  } gfl_out_t;

  // saturating fill count update
  function automatic logic [FILL_W-1:0] sat_add(input logic [FILL_W-1:0] a,
                                                input logic [CNT_W-1:0]  b);
    logic [FILL_W:0] s;
    s = {1'b0, a} + {{(FILL_W + 1 - CNT_W){1'b0}}, b};
    return s[FILL_W] ? {FILL_W{1'b1}} : s[FILL_W-1:0];
  endfunction

endpackage

FILE: design/gap_fill_linear_interp.sv
// gap_fill_linear_interp: linear interpolation gap filler with bit-serial step divider
// A sample with no pending gap goes from ST_IDLE via ST_EMIT into the output register,
// which waits while the output is stalled; the next item is taken back in ST_IDLE.
// A gap after a valid sample runs the restoring divider one quotient bit per cycle
// (NUM_W = 32 quotient bits), ST_STEP then forms the step, and ST_EMIT gives the results.
// Other gaps and flushes go straight to ST_EMIT; one item is worked at a time.
// Reset (rst_ni low, async) clears all record state and empties the output register.
`timescale 1ns / 1ps

module gap_fill_linear_interp import gfl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  gfl_in_t  in_item_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output gfl_out_t out_item_o
);

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_STEP, ST_EMIT} state_e;

  state_e state_q, state_d;

  // record state
  logic [SAMPLE_BITS-1:0] last_good_q, last_good_d;
  logic                   seen_q, seen_d;
  logic [PEND_W-1:0]      pend_q, pend_d;
  logic [FILL_W-1:0]      fcnt_q, fcnt_d;
  logic                   ovf_q, ovf_d;

  // current run
  logic [CNT_W-1:0]       fill_left_q, fill_left_d;
  logic                   tail_q, tail_d;
  logic                   interp_q, interp_d;
  logic [SAMPLE_BITS-1:0] hold_q, hold_d;
  logic                   filled_q, filled_d;
  logic [1:0]             stat_q, stat_d;
  logic                   rend_q, rend_d;
  logic [1:0]             fin_stat_q, fin_stat_d;
  logic [FILL_W-1:0]      fin_total_q, fin_total_d;

  // divider and accumulator
  logic [NUM_W-1:0]       num_q, num_d;
  logic [CNT_W-1:0]       rem_q, rem_d;
  logic [CNT_W-1:0]       dvs_q, dvs_d;
  logic [DIV_CNT_W-1:0]   div_cnt_q, div_cnt_d;
  logic                   neg_q, neg_d;
  logic [ACC_W-1:0]       acc_q, acc_d;
  logic [ACC_W-1:0]       step_q, step_d;

  logic                   out_valid_q, out_valid_d;
  gfl_out_t               out_q, out_d;

  logic                   accept;
  logic                   slot_free;
  logic [SAMPLE_BITS:0]   diff;
  logic [SAMPLE_BITS-1:0] mag;
  logic [CNT_W-1:0]       pend_ext;
  logic [CNT_W-1:0]       pend_p1;
  logic [FILL_W-1:0]      fc_new;
  logic                   novalid;
  logic                   ovf_new;
  logic [CNT_W:0]         rem_sh;
  logic                   q_bit;
  logic [CNT_W:0]         rem_sub;
  logic [ACC_W-1:0]       q_ext;
  logic [ACC_W-1:0]       lg_ext;
  logic [SAMPLE_BITS+1:0] acc_int;
  logic [SAMPLE_BITS-1:0] interp_val;
  logic                   is_last;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign diff     = {in_item_i.sample[SAMPLE_BITS-1], in_item_i.sample}
                  - {last_good_q[SAMPLE_BITS-1], last_good_q};
  assign mag      = diff[SAMPLE_BITS] ? SAMPLE_BITS'(-diff) : diff[SAMPLE_BITS-1:0];
  assign pend_ext = {1'b0, pend_q};
  assign pend_p1  = pend_ext + CNT_W'(1);
  assign novalid  = !in_item_i.sample_valid && in_item_i.record_end && !seen_q;
  assign lg_ext   = {{(ACC_W - NUM_W){last_good_q[SAMPLE_BITS-1]}}, last_good_q,
                     {FRAC_BITS{1'b0}}};

  // restoring division step: one quotient bit per cycle
  assign rem_sh  = {rem_q, num_q[NUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};
  assign q_bit   = (rem_sh >= {1'b0, dvs_q});
  assign q_ext   = {{(ACC_W - NUM_W){1'b0}}, num_q};

  // round-to-nearest already folded into acc, clamp when guard bits disagree
  assign acc_int = acc_q[ACC_W-1:FRAC_BITS];
  always_comb begin
    if (acc_int[SAMPLE_BITS+1:SAMPLE_BITS-1] == 3'b000 ||
        acc_int[SAMPLE_BITS+1:SAMPLE_BITS-1] == 3'b111) begin
      interp_val = acc_int[SAMPLE_BITS-1:0];
    end else if (acc_int[SAMPLE_BITS+1]) begin
      interp_val = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
    end else begin
      interp_val = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    end
  end

  assign is_last = (fill_left_q == '0) || (fill_left_q == CNT_W'(1) && !tail_q);

  always_comb begin
    state_d     = state_q;
    last_good_d = last_good_q;
    seen_d      = seen_q;
    pend_d      = pend_q;
    fcnt_d      = fcnt_q;
    ovf_d       = ovf_q;
    fill_left_d = fill_left_q;
    tail_d      = tail_q;
    interp_d    = interp_q;
    hold_d      = hold_q;
    filled_d    = filled_q;
    stat_d      = stat_q;
    rend_d      = rend_q;
    fin_stat_d  = fin_stat_q;
    fin_total_d = fin_total_q;
    num_d       = num_q;
    rem_d       = rem_q;
    dvs_d       = dvs_q;
    div_cnt_d   = div_cnt_q;
    neg_d       = neg_q;
    acc_d       = acc_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    fc_new      = fcnt_q;
    ovf_new     = ovf_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          rend_d   = in_item_i.record_end;
          interp_d = 1'b0;
          // divider setup for an interpolated gap
          num_d     = {mag, {FRAC_BITS{1'b0}}} + NUM_W'(pend_p1 >> 1);
          rem_d     = '0;
          dvs_d     = pend_p1;
          div_cnt_d = DIV_CNT_W'(NUM_W - 1);
          neg_d     = diff[SAMPLE_BITS];
          acc_d     = lg_ext + ROUND_HALF;
          if (in_item_i.sample_valid) begin
            fill_left_d = pend_ext;
            tail_d      = 1'b1;
            interp_d    = seen_q && (pend_q != '0);
            hold_d      = in_item_i.sample;
            filled_d    = 1'b1;
            stat_d      = STATUS_OK;
            fc_new      = sat_add(fcnt_q, pend_ext);
            last_good_d = in_item_i.sample;
            seen_d      = 1'b1;
            pend_d      = '0;
            state_d     = (seen_q && (pend_q != '0)) ? ST_DIV : ST_EMIT;
          end else if (in_item_i.record_end) begin
            fill_left_d = pend_p1;
            tail_d      = 1'b0;
            hold_d      = seen_q ? last_good_q : '0;
            filled_d    = seen_q;
            stat_d      = seen_q ? STATUS_OK : STATUS_NOVALID;
            fc_new      = seen_q ? sat_add(fcnt_q, pend_p1) : fcnt_q;
            pend_d      = '0;
            state_d     = ST_EMIT;
          end else if (pend_q >= PEND_W'(MAX_GAP)) begin
            // early flush of an overlong gap with the held value
            fill_left_d = pend_p1;
            tail_d      = 1'b0;
            hold_d      = last_good_q;
            filled_d    = 1'b1;
            stat_d      = STATUS_OVF;
            fc_new      = sat_add(fcnt_q, pend_p1);
            ovf_new     = 1'b1;
            pend_d      = '0;
            state_d     = ST_EMIT;
          end else begin
            pend_d = pend_q + PEND_W'(1);
          end
          fcnt_d = fc_new;
          ovf_d  = ovf_new;
          fin_stat_d  = novalid ? STATUS_NOVALID : (ovf_new ? STATUS_OVF : STATUS_OK);
          fin_total_d = novalid ? '0 : fc_new;
          if (in_item_i.record_end) begin
            last_good_d = '0;
            seen_d      = 1'b0;
            pend_d      = '0;
            fcnt_d      = '0;
            ovf_d       = 1'b0;
          end
        end
      end
      ST_DIV: begin
        rem_d = q_bit ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        num_d = {num_q[NUM_W-2:0], q_bit};
        if (div_cnt_q == '0) begin
          state_d = ST_STEP;
        end else begin
          div_cnt_d = div_cnt_q - DIV_CNT_W'(1);
        end
      end
      ST_STEP: begin
        step_d  = neg_q ? -q_ext : q_ext;
        acc_d   = acc_q + (neg_q ? -q_ext : q_ext);
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          if (fill_left_q != '0) begin
            out_d.value      = interp_q ? interp_val : hold_q;
            out_d.was_filled = filled_q;
            out_d.status     = stat_q;
            fill_left_d      = fill_left_q - CNT_W'(1);
            acc_d            = acc_q + step_q;
          end else begin
            out_d.value      = hold_q;
            out_d.was_filled = 1'b0;
            out_d.status     = STATUS_OK;
          end
          out_d.run_last     = is_last;
          out_d.record_done  = is_last && rend_q;
          out_d.filled_total = '0;
          if (is_last && rend_q) begin
            out_d.status       = fin_stat_q;
            out_d.filled_total = fin_total_q;
          end
          if (is_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      last_good_q <= '0;
      seen_q      <= 1'b0;
      pend_q      <= '0;
      fcnt_q      <= '0;
      ovf_q       <= 1'b0;
      fill_left_q <= '0;
      tail_q      <= 1'b0;
      interp_q    <= 1'b0;
      hold_q      <= '0;
      filled_q    <= 1'b0;
      stat_q      <= STATUS_OK;
      rend_q      <= 1'b0;
      fin_stat_q  <= STATUS_OK;
      fin_total_q <= '0;
      num_q       <= '0;
      rem_q       <= '0;
      dvs_q       <= '0;
      div_cnt_q   <= '0;
      neg_q       <= 1'b0;
      acc_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      last_good_q <= last_good_d;
      seen_q      <= seen_d;
      pend_q      <= pend_d;
      fcnt_q      <= fcnt_d;
      ovf_q       <= ovf_d;
      fill_left_q <= fill_left_d;
      tail_q      <= tail_d;
      interp_q    <= interp_d;
      hold_q      <= hold_d;
      filled_q    <= filled_d;
      stat_q      <= stat_d;
      rend_q      <= rend_d;
      fin_stat_q  <= fin_stat_d;
      fin_total_q <= fin_total_d;
      num_q       <= num_d;
      rem_q       <= rem_d;
      dvs_q       <= dvs_d;
      div_cnt_q   <= div_cnt_d;
      neg_q       <= neg_d;
      acc_q       <= acc_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

endmodule
